// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the fuzzy PID gain scheduler.
// No dependencies; modules that check themselves include this file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Concurrent check on clk, muted while rst_n is low.
`define CHK_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be seen at a clock edge.
`define CHK_NEVER(lbl, expr, msg) \
  `CHK_PROP(lbl, !(expr), msg)
`else
`define CHK_PROP(lbl, prop, msg)
`define CHK_NEVER(lbl, expr, msg)
`endif

`endif

// File: hw/rtl/fpgs_pkg.sv
// Shared types and constants of the fuzzy PID gain scheduler.
// No dependencies.
package fpgs_pkg;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    REG_ERROR_CENTER = 3'd0,
    REG_ERROR_SCALE  = 3'd1,
    REG_RATE_CENTER  = 3'd2,
    REG_RATE_SCALE   = 3'd3,
    REG_KP_MAX       = 3'd4,
    REG_KI_MAX       = 3'd5,
    REG_KD_MAX       = 3'd6
  } reg_idx_t;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned FRAC_W   = 17;                 // Q0.16 plus the "one" bit
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;
  localparam int unsigned Q_FRAC   = 8;                  // Q8.8 scale factors
  localparam int unsigned DIFF_W   = SAMPLE_W + 1;
  localparam int unsigned PROD_W   = 2 * DIFF_W;
  localparam int unsigned LEVEL_W  = PROD_W - Q_FRAC;

  // rule memory port control
  typedef struct packed {
    logic en;
    logic we;
  } mem_ctl_t;

endpackage

// File: hw/rtl/fuzzy_pid_gain_scheduler_unit.sv
// Fuzzy PID gain scheduler, top level: config registers, six-stage pipeline.
// Depends on fpgs_pkg, fpgs_rule_mem and assert_macros.svh.
//
// Usage:
//  - in_* carries items. in_tuser[0] is the opcode: a load item writes
//    load_value (saturated to one) into the rule table at (load_row, load_col)
//    and yields no result; a compute item yields exactly one result on out_*.
//  - A compute item centres both samples, scales them by the Q8.8 factors and
//    truncates toward zero to levels. If both lie within +-SET_LENGTH the table
//    word u at (rate level, error level) gives kp = u*kp_max, ki and kd from
//    (1-u); else out_tuser[0] (in_range) is 0 and all gains are 0.
//  - cfg_* writes register cfg_addr (index 7 is ignored). cfg_ready is always
//    high; write only while no item is in flight.
//  - The result is registered in stage 6 (out_tvalid, out_tdata). Throughput:
//    one item per cycle, unless a low out_tready has filled every stage.
//  - Loads and computes touch the table at the same stage boundary, so a
//    compute sees exactly the loads accepted before it.
//  - When out_tready is low, results hold in the output stage; bubbles behind
//    it still close up, and in_tready drops only once every stage is full.
//  - Reset (rst_n low, synchronous) empties the pipeline and restores the
//    register defaults. Table words are undefined until loaded.
`include "assert_macros.svh"

module fuzzy_pid_gain_scheduler_unit
  import fpgs_pkg::*;
#(
  parameter int unsigned SET_LENGTH = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_data,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] error_sample, [31:16] rate_sample, [35:32] load_row,
  // [39:36] load_col, [56:40] load_value, [63:57] zero
  input  logic [63:0] in_tdata,
  // [0] opcode
  input  logic [0:0]  in_tuser,
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] kp_gain, [31:16] ki_gain, [47:32] kd_gain
  output logic [47:0] out_tdata,
  // [0] in_range
  output logic [0:0]  out_tuser
);

  localparam int unsigned SIDE  = 2 * SET_LENGTH + 1;
  localparam int unsigned DEPTH = SIDE * SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = $clog2(SIDE);
  localparam logic signed [LEVEL_W-1:0] LV_LIM = LEVEL_W'(SET_LENGTH);
  localparam logic signed [PROD_W-1:0]  TRUNC_BIAS = PROD_W'((1 << Q_FRAC) - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [CFG_W-1:0] error_center_r, rate_center_r;
  logic [CFG_W-1:0] error_scale_r, rate_scale_r;
  logic [CFG_W-1:0] kp_max_r, ki_max_r, kd_max_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_center_r <= '0;
      error_scale_r  <= CFG_W'(1 << Q_FRAC);
      rate_center_r  <= '0;
      rate_scale_r   <= CFG_W'(1 << Q_FRAC);
      kp_max_r       <= '0;
      ki_max_r       <= '0;
      kd_max_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_ERROR_CENTER: error_center_r <= cfg_data;
        REG_ERROR_SCALE:  error_scale_r  <= cfg_data;
        REG_RATE_CENTER:  rate_center_r  <= cfg_data;
        REG_RATE_SCALE:   rate_scale_r   <= cfg_data;
        REG_KP_MAX:       kp_max_r       <= cfg_data;
        REG_KI_MAX:       ki_max_r       <= cfg_data;
        REG_KD_MAX:       kd_max_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage handshake: a stage loads when empty or when its content moves on
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6_r || out_tready;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_tready = en1;

  // input fields
  logic signed [SAMPLE_W-1:0] in_err, in_rate;
  logic [3:0]        in_row, in_col;
  logic [FRAC_W-1:0] in_val;
  opcode_t           in_op;

  assign in_err  = in_tdata[15:0];
  assign in_rate = in_tdata[31:16];
  assign in_row  = in_tdata[35:32];
  assign in_col  = in_tdata[39:36];
  assign in_val  = in_tdata[56:40];
  assign in_op   = opcode_t'(in_tuser[0]);

  // ---------------------------------------------------------------------------
  // Stage 1: centre samples, decode load address, saturate load word
  // ---------------------------------------------------------------------------
  opcode_t op1_r;
  logic signed [DIFF_W-1:0] derr1_r, drate1_r, derr1_nxt, drate1_nxt;
  logic lok1_r, lok1_nxt;
  logic [AW-1:0] laddr1_r, laddr1_nxt;
  logic [FRAC_W-1:0] lval1_r, lval1_nxt;

  always_comb begin
    derr1_nxt  = DIFF_W'(in_err) - DIFF_W'(error_center_r);
    drate1_nxt = DIFF_W'(in_rate) - DIFF_W'(rate_center_r);
    lok1_nxt   = (32'(in_row) < SIDE) && (32'(in_col) < SIDE);
    laddr1_nxt = AW'(32'(in_row) * SIDE + 32'(in_col));
    lval1_nxt  = (in_val > FRAC_ONE) ? FRAC_ONE : in_val;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: Q8.8 scaling products
  // ---------------------------------------------------------------------------
  opcode_t op2_r;
  logic signed [PROD_W-1:0] perr2_r, prate2_r, perr2_nxt, prate2_nxt;
  logic lok2_r;
  logic [AW-1:0] laddr2_r;
  logic [FRAC_W-1:0] lval2_r;

  always_comb begin
    perr2_nxt  = derr1_r * $signed({1'b0, error_scale_r});
    prate2_nxt = drate1_r * $signed({1'b0, rate_scale_r});
  end

  // ---------------------------------------------------------------------------
  // Stage 3: truncate toward zero to levels, range check, table indexes
  // ---------------------------------------------------------------------------
  opcode_t op3_r;
  logic inr3_r, inr3_nxt;
  logic [RW-1:0] eidx3_r, ridx3_r, eidx3_nxt, ridx3_nxt;
  logic lok3_r;
  logic [AW-1:0] laddr3_r;
  logic [FRAC_W-1:0] lval3_r;

  always_comb begin
    logic signed [PROD_W-1:0]  ebias, rbias;
    logic signed [LEVEL_W-1:0] elvl, rlvl, eoff, roff;
    ebias = perr2_r + (perr2_r[PROD_W-1] ? TRUNC_BIAS : '0);
    rbias = prate2_r + (prate2_r[PROD_W-1] ? TRUNC_BIAS : '0);
    elvl  = ebias[PROD_W-1:Q_FRAC];
    rlvl  = rbias[PROD_W-1:Q_FRAC];
    inr3_nxt = (elvl >= -LV_LIM) && (elvl <= LV_LIM) &&
               (rlvl >= -LV_LIM) && (rlvl <= LV_LIM);
    eoff  = elvl + LV_LIM;
    roff  = rlvl + LV_LIM;
    eidx3_nxt = eoff[RW-1:0];
    ridx3_nxt = roff[RW-1:0];
  end

  // ---------------------------------------------------------------------------
  // Stage 4: table address for both item kinds
  // ---------------------------------------------------------------------------
  opcode_t op4_r;
  logic inr4_r, lok4_r;
  logic [AW-1:0] addr4_r, addr4_nxt;
  logic [FRAC_W-1:0] lval4_r;

  always_comb begin
    if (op3_r == OP_LOAD) begin
      addr4_nxt = laddr3_r;
    end else begin
      addr4_nxt = AW'(32'(ridx3_r) * SIDE + 32'(eidx3_r));
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: table access (loads leave, writing if in the table; in-range computes read u)
  // ---------------------------------------------------------------------------
  logic inr5_r;
  logic [FRAC_W-1:0] u5;
  mem_ctl_t mem_ctl;

  always_comb begin
    mem_ctl.we = (op4_r == OP_LOAD);
    mem_ctl.en = en5 && v4_r && (mem_ctl.we ? lok4_r : inr4_r);
  end

  fpgs_rule_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_rule_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .addr    (addr4_r),
    .wr_data (lval4_r),
    .rd_data (u5)
  );

  // ---------------------------------------------------------------------------
  // Stage 6: gain products, output register
  // ---------------------------------------------------------------------------
  logic inr6_r;
  logic [GAIN_W-1:0] kp6_r, ki6_r, kd6_r, kp6_nxt, ki6_nxt, kd6_nxt;

  always_comb begin
    logic [FRAC_W-1:0] nu;
    logic [FRAC_W+GAIN_W-1:0] pkp, pki, pkd;
    nu  = FRAC_ONE - u5;
    pkp = u5 * kp_max_r;
    pki = nu * ki_max_r;
    pkd = nu * kd_max_r;
    if (inr5_r) begin
      kp6_nxt = pkp[2*GAIN_W-1:GAIN_W];
      ki6_nxt = pki[2*GAIN_W-1:GAIN_W];
      kd6_nxt = pkd[2*GAIN_W-1:GAIN_W];
    end else begin
      kp6_nxt = '0;
      ki6_nxt = '0;
      kd6_nxt = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bits
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r && (op4_r == OP_COMPUTE);
      if (en6) v6_r <= v5_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en1) begin
      op1_r    <= in_op;
      derr1_r  <= derr1_nxt;
      drate1_r <= drate1_nxt;
      lok1_r   <= lok1_nxt;
      laddr1_r <= laddr1_nxt;
      lval1_r  <= lval1_nxt;
    end
    if (en2) begin
      op2_r    <= op1_r;
      perr2_r  <= perr2_nxt;
      prate2_r <= prate2_nxt;
      lok2_r   <= lok1_r;
      laddr2_r <= laddr1_r;
      lval2_r  <= lval1_r;
    end
    if (en3) begin
      op3_r    <= op2_r;
      inr3_r   <= inr3_nxt;
      eidx3_r  <= eidx3_nxt;
      ridx3_r  <= ridx3_nxt;
      lok3_r   <= lok2_r;
      laddr3_r <= laddr2_r;
      lval3_r  <= lval2_r;
    end
    if (en4) begin
      op4_r   <= op3_r;
      inr4_r  <= inr3_r;
      lok4_r  <= lok3_r;
      addr4_r <= addr4_nxt;
      lval4_r <= lval3_r;
    end
    if (en5) begin
      inr5_r <= inr4_r;
    end
    if (en6) begin
      inr6_r <= inr5_r;
      kp6_r  <= kp6_nxt;
      ki6_r  <= ki6_nxt;
      kd6_r  <= kd6_nxt;
    end
  end

  assign out_tvalid = v6_r;
  assign out_tdata  = {kd6_r, ki6_r, kp6_r};
  assign out_tuser  = inr6_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `CHK_PROP(a_oor_zero, (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0),
            "out of range result carries nonzero gains")
  `CHK_PROP(a_empty_ready,
            !(v1_r || v2_r || v3_r || v4_r || v5_r || v6_r) |-> in_tready,
            "empty pipeline refuses input")
  `CHK_PROP(a_ki_kd_match,
            (out_tvalid && out_tuser[0] && (ki_max_r == kd_max_r)) |->
            (out_tdata[31:16] == out_tdata[47:32]),
            "ki and kd differ for equal maxima")
  `CHK_PROP(a_kp_zero, (out_tvalid && (kp_max_r == '0)) |-> (out_tdata[15:0] == '0),
            "kp nonzero with zero kp_max")

endmodule

// File: hw/rtl/fpgs_rule_mem.sv
// Single-port rule table memory with registered read data.
// Depends on fpgs_pkg.
module fpgs_rule_mem
  import fpgs_pkg::*;
#(
  parameter int unsigned DEPTH = 225,
  parameter int unsigned AW    = 8
) (
  input  logic              clk,
  input  mem_ctl_t          ctl,
  input  logic [AW-1:0]     addr,
  input  logic [FRAC_W-1:0] wr_data,
  output logic [FRAC_W-1:0] rd_data
);

  logic [FRAC_W-1:0] mem [DEPTH];
  logic [FRAC_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.we) begin
        mem[addr] <= wr_data;
      end else begin
        rd_data_r <= mem[addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: bench/tb.sv
// Self-checking bench for fuzzy_pid_gain_scheduler_unit: directed table, then random phases.
// Depends on fpgs_pkg and the unit's RTL; the gain schedule is predicted in the bench itself.
module tb
  import fpgs_pkg::*;
();

  localparam int SET_LEN    = 7;
  localparam int SIDE       = 2 * SET_LEN + 1;
  localparam int QUIET_MAX  = 2000;  // cycles with no handshake on any channel
  localparam int DRAIN_WAIT = 8;     // pipeline is six stages deep
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct {
    opcode_t            op;
    logic signed [15:0] err;
    logic signed [15:0] rate;
    logic [3:0]         row;
    logic [3:0]         col;
    logic [16:0]        val;
  } sample_item_t;

  typedef struct {
    logic        in_range;
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] kd;
  } gains_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_ITEM
  } row_kind_t;

  typedef struct {
    row_kind_t    kind;
    logic [2:0]   addr;
    logic [15:0]  data;
    sample_item_t item;
    bit           typed;  // expected gains written out in the row
    gains_t       want;
  } script_row_t;

  // DUT ports; every input starts at a known value
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_addr   = '0;
  logic [15:0] cfg_data   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [0:0]  out_tuser;

  fuzzy_pid_gain_scheduler_unit #(.SET_LENGTH(SET_LEN)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // Shadow copy of the unit: registers and rule table
  logic signed [15:0] err_mid      = '0;
  logic [15:0]        err_gain_q8  = 16'd256;
  logic signed [15:0] rate_mid     = '0;
  logic [15:0]        rate_gain_q8 = 16'd256;
  logic [15:0]        kp_top       = '0;
  logic [15:0]        ki_top       = '0;
  logic [15:0]        kd_top       = '0;
  logic [16:0]        frac_table [0:SIDE-1][0:SIDE-1];

  gains_t      pending_gains[$];
  script_row_t script[$];

  int  err_cnt;
  int  n_loads, n_computes, n_outside, n_reg_writes, n_results;
  bit  tx_calm, rx_calm;  // calm = no idle cycles on that side
  int  stall_left;
  int  quiet;

  task automatic report(string what, longint got, longint want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------- predictor
  // level = (sample - centre) * scale / 256, truncated toward zero
  function automatic longint level_of(logic signed [15:0] s, logic signed [15:0] c,
                                      logic [15:0] k);
    longint d;
    d = longint'(s) - longint'(c);
    return (d * longint'({48'd0, k})) / 256;
  endfunction

  function automatic gains_t mk_gains(logic r, logic [15:0] kp, logic [15:0] ki,
                                      logic [15:0] kd);
    gains_t g;
    g.in_range = r;
    g.kp = kp;
    g.ki = ki;
    g.kd = kd;
    return g;
  endfunction

  function automatic gains_t schedule_gains(sample_item_t it);
    longint el, rl, u, nu;
    el = level_of(it.err, err_mid, err_gain_q8);
    rl = level_of(it.rate, rate_mid, rate_gain_q8);
    if (el < -SET_LEN || el > SET_LEN || rl < -SET_LEN || rl > SET_LEN)
      return mk_gains(1'b0, '0, '0, '0);
    u  = longint'({47'd0, frac_table[int'(rl) + SET_LEN][int'(el) + SET_LEN]});
    nu = 65536 - u;
    return mk_gains(1'b1, 16'((u * longint'({48'd0, kp_top})) >>> 16),
                    16'((nu * longint'({48'd0, ki_top})) >>> 16),
                    16'((nu * longint'({48'd0, kd_top})) >>> 16));
  endfunction

  // Loads update the shadow table; computes queue their expected gains.
  task automatic take_item(sample_item_t it, bit typed, gains_t want);
    gains_t g;
    if (it.op == OP_LOAD) begin
      n_loads++;
      if (it.row < SIDE && it.col < SIDE)
        frac_table[it.row][it.col] = (it.val > FRAC_ONE) ? FRAC_ONE : it.val;
    end else begin
      n_computes++;
      g = typed ? want : schedule_gains(it);
      if (!g.in_range) n_outside++;
      pending_gains.push_back(g);
    end
  endtask

  // ---------------------------------------------------------------- drivers
  // Valid is left high after a handshake; the next call lowers it only for a gap.
  task automatic send_item(sample_item_t it, bit typed = 1'b0,
                           gains_t want = '{1'b0, 16'd0, 16'd0, 16'd0});
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, it.val, it.col, it.row, it.rate, it.err};
    in_tuser  <= it.op;
    do @(posedge clk); while (!in_tready);
    take_item(it, typed, want);
  endtask

  // Sender holds off until every result is back, then lets loads drain.
  task automatic settle();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_gains.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] a, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_addr  <= a;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    n_reg_writes++;
    case (a)
      REG_ERROR_CENTER: err_mid      = v;
      REG_ERROR_SCALE:  err_gain_q8  = v;
      REG_RATE_CENTER:  rate_mid     = v;
      REG_RATE_SCALE:   rate_gain_q8 = v;
      REG_KP_MAX:       kp_top       = v;
      REG_KI_MAX:       ki_top       = v;
      REG_KD_MAX:       kd_top       = v;
      default: ;  // unused index, no effect
    endcase
  endtask

  // ---------------------------------------------------------------- stimulus helpers
  function automatic sample_item_t mk_load(logic [3:0] r, logic [3:0] c, logic [16:0] v);
    sample_item_t it;
    it.op   = OP_LOAD;
    it.err  = 16'($urandom);   // don't-care fields still toggle
    it.rate = 16'($urandom);
    it.row  = r;
    it.col  = c;
    it.val  = v;
    return it;
  endfunction

  function automatic sample_item_t mk_comp(logic signed [15:0] e, logic signed [15:0] r);
    sample_item_t it;
    it.op   = OP_COMPUTE;
    it.err  = e;
    it.rate = r;
    it.row  = 4'($urandom);
    it.col  = 4'($urandom);
    it.val  = 17'($urandom);
    return it;
  endfunction

  function automatic void add_cfg(logic [2:0] a, logic [15:0] v);
    script_row_t s;
    s.kind = ROW_CFG;
    s.addr = a;
    s.data = v;
    s.typed = 1'b0;
    script.push_back(s);
  endfunction

  function automatic void add_item(sample_item_t it, bit typed = 1'b0,
                                   gains_t want = '{1'b0, 16'd0, 16'd0, 16'd0});
    script_row_t s;
    s.kind  = ROW_ITEM;
    s.item  = it;
    s.typed = typed;
    s.want  = want;
    script.push_back(s);
  endfunction

  function automatic logic [16:0] draw_frac();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return FRAC_ONE;
      2:       return 17'h1FFFF;
      3:       return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [15:0] draw_word();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] draw_scale();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'd256;
      3:       return 16'($urandom_range(1, 127));
      4, 5:    return 16'($urandom_range(1, 1023));
      default: return 16'($urandom);
    endcase
  endfunction

  // Sample that lands within a couple of levels of the table edge or inside it
  function automatic logic signed [15:0] near_table(logic signed [15:0] c, logic [15:0] k);
    longint span, v;
    span = (k == 0) ? 32767 : (9 * 256) / longint'({48'd0, k}) + 1;
    if (span > 32767) span = 32767;
    v = longint'(c) + longint'($urandom_range(0, 2 * int'(span))) - span;
    if (v > 32767)  v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // ---------------------------------------------------------------- result side
  // Receiver stalls a drawn number of cycles after each result unless rx_calm is set; checks in order.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (pending_gains.size() == 0) begin
          report("result with nothing pending", {out_tuser, out_tdata}, 0);
        end else begin
          gains_t exp_g;
          exp_g = pending_gains.pop_front();
          if (out_tuser[0] !== exp_g.in_range) report("in_range", out_tuser[0], exp_g.in_range);
          if (out_tdata[15:0] !== exp_g.kp)    report("kp_gain", out_tdata[15:0], exp_g.kp);
          if (out_tdata[31:16] !== exp_g.ki)   report("ki_gain", out_tdata[31:16], exp_g.ki);
          if (out_tdata[47:32] !== exp_g.kd)   report("kd_gain", out_tdata[47:32], exp_g.kd);
        end
        stall_left = rx_calm ? 0 : $urandom_range(0, 7);
      end
      out_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Watchdog: any handshake counts as progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_MAX) begin
      $display("[%0t] watchdog: no handshake for %0d cycles, %0d results pending",
               $time, QUIET_MAX, pending_gains.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main sequence
  initial begin
    sample_item_t it;
    quiet = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Table is undefined after reset: load every word before any compute.
    for (int r = 0; r < SIDE; r++)
      for (int c = 0; c < SIDE; c++)
        send_item(mk_load(4'(r), 4'(c), draw_frac()));

    // Directed rows. Reset config: unity scales, zero centres, zero gain maxima.
    add_item(mk_comp(16'sd0, 16'sd0), 1'b1, mk_gains(1'b1, 16'd0, 16'd0, 16'd0));
    add_item(mk_comp(16'sd7, -16'sd7), 1'b1, mk_gains(1'b1, 16'd0, 16'd0, 16'd0));
    add_item(mk_comp(-16'sd8, 16'sd0), 1'b1, mk_gains(1'b0, 16'd0, 16'd0, 16'd0));
    add_item(mk_comp(16'sd0, 16'sd8), 1'b1, mk_gains(1'b0, 16'd0, 16'd0, 16'd0));
    add_item(mk_comp(16'sh7FFF, 16'sh8000), 1'b1, mk_gains(1'b0, 16'd0, 16'd0, 16'd0));
    // full-scale gain maxima
    add_cfg(REG_KP_MAX, 16'hFFFF);
    add_cfg(REG_KI_MAX, 16'hFFFF);
    add_cfg(REG_KD_MAX, 16'hFFFF);
    // u = one, u = zero, then an oversized word that must saturate
    add_item(mk_load(4'd7, 4'd7, FRAC_ONE));
    add_item(mk_comp(16'sd0, 16'sd0), 1'b1, mk_gains(1'b1, 16'hFFFF, 16'd0, 16'd0));
    add_item(mk_load(4'd7, 4'd7, 17'd0));
    add_item(mk_comp(16'sd0, 16'sd0), 1'b1, mk_gains(1'b1, 16'd0, 16'hFFFF, 16'hFFFF));
    add_item(mk_load(4'd7, 4'd7, 17'h1FFFF));
    add_item(mk_comp(16'sd0, 16'sd0), 1'b1, mk_gains(1'b1, 16'hFFFF, 16'd0, 16'd0));
    // loads addressed past the table edge are dropped
    add_item(mk_load(4'd15, 4'd7, 17'd0));
    add_item(mk_load(4'd7, 4'd15, 17'd0));
    add_item(mk_comp(16'sd0, 16'sd0), 1'b1, mk_gains(1'b1, 16'hFFFF, 16'd0, 16'd0));
    // table corners
    add_item(mk_load(4'd0, 4'd0, 17'h08000));
    add_item(mk_comp(-16'sd7, -16'sd7));
    add_item(mk_load(4'd14, 4'd14, 17'd1));
    add_item(mk_comp(16'sd7, 16'sd7));
    // scale 1.5: truncation toward zero on both signs
    add_cfg(REG_ERROR_SCALE, 16'h0180);
    add_cfg(REG_RATE_SCALE, 16'h0180);
    add_item(mk_comp(-16'sd5, 16'sd5));
    add_item(mk_comp(16'sd6, 16'sd0), 1'b1, mk_gains(1'b0, 16'd0, 16'd0, 16'd0));
    // extreme scales and centres: scale zero pins the level at zero
    add_cfg(REG_ERROR_SCALE, 16'h0000);
    add_cfg(REG_RATE_SCALE, 16'hFFFF);
    add_cfg(REG_ERROR_CENTER, 16'h8000);
    add_cfg(REG_RATE_CENTER, 16'h7FFF);
    add_item(mk_comp(16'sh7FFF, 16'sh7FFF));
    add_item(mk_comp(16'sd0, 16'sh7FFE), 1'b1, mk_gains(1'b0, 16'd0, 16'd0, 16'd0));
    // write to the unused register index must change nothing
    add_cfg(REG_UNUSED, 16'hFFFF);
    add_item(mk_comp(16'sh8000, 16'sh7FFF));

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        settle();
        write_reg(script[i].addr, script[i].data);
      end else begin
        send_item(script[i].item, script[i].typed, script[i].want);
      end
    end

    // Random phases: fresh register set each phase, mostly in-table samples.
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      write_reg(REG_ERROR_CENTER, draw_word());
      write_reg(REG_ERROR_SCALE, draw_scale());
      write_reg(REG_RATE_CENTER, draw_word());
      write_reg(REG_RATE_SCALE, draw_scale());
      write_reg(REG_KP_MAX, draw_word());
      write_reg(REG_KI_MAX, draw_word());
      write_reg(REG_KD_MAX, draw_word());
      if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, 16'($urandom));
      tx_calm = (ph % 3 == 2);
      rx_calm = (ph % 4 == 1);
      for (int n = 0; n < 170; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          it = mk_load(4'($urandom_range(0, (($urandom_range(0, 9) == 0) ? 15 : 14))),
                       4'($urandom_range(0, (($urandom_range(0, 9) == 0) ? 15 : 14))),
                       draw_frac());
        end else if ($urandom_range(0, 4) == 0) begin
          it = mk_comp(16'($urandom), 16'($urandom));  // mostly off the table
        end else begin
          it = mk_comp(near_table(err_mid, err_gain_q8), near_table(rate_mid, rate_gain_q8));
        end
        send_item(it);
      end
    end

    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_gains.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_gains.size() != 0)
      report("results never delivered", pending_gains.size(), 0);

    $display("Run: %0d loads, %0d computes (%0d outside the table), %0d register writes",
             n_loads, n_computes, n_outside, n_reg_writes);
    $display("     %0d results checked, %0d mismatches", n_results, err_cnt);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
